// ===== design/mm3_pkg.sv =====
// mm3_pkg: shared types, constants and helper functions for the murmur3 x64_128 hasher
// used by mm3_ctrl, mm3_datapath and murmur3_hash_128; depends on nothing else

package mm3_pkg;

    localparam logic [63:0] MUL_A      = 64'h87c37b91114253d5;
    localparam logic [63:0] MUL_B      = 64'h4cf5ad432745937f;
    localparam logic [63:0] ADD_ONE    = 64'h0000000052dce729;
    localparam logic [63:0] ADD_TWO    = 64'h0000000038495ab5;
    localparam logic [63:0] FIN_A      = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_B      = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] SEED_RESET = 64'hdeadbeefdeadbeef;

    localparam int unsigned STEP_W = 6;
    // last step of block mixing, and the step that hands over the result
    localparam logic [STEP_W-1:0] STEP_BLOCK_END = 6'd19;
    localparam logic [STEP_W-1:0] STEP_RESULT    = 6'd43;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_W_K1,
        OP_W_K2,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_W_ROT31,
        OP_W_ROT33,
        OP_K1_ACC,
        OP_K2_ACC,
        OP_MERGE1,
        OP_MERGE2,
        OP_FIN_XOR,
        OP_FIN_ADD1,
        OP_FIN_ADD2,
        OP_W_L1_FM,
        OP_W_L2_FM,
        OP_W_ACC_FM,
        OP_L1_ACC_FM,
        OP_L2_ACC_FM,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [1:0] {
        MC_A,
        MC_B,
        MC_FA,
        MC_FB
    } mul_const_t;

    typedef struct packed {
        dp_op_t     op;
        mul_const_t csel;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic [63:0] rotl27(input logic [63:0] x);
        return {x[36:0], x[63:37]};
    endfunction

    function automatic logic [63:0] rotl31(input logic [63:0] x);
        return {x[32:0], x[63:33]};
    endfunction

    function automatic logic [63:0] rotl33(input logic [63:0] x);
        return {x[30:0], x[63:31]};
    endfunction

    function automatic logic [63:0] shr33_xor(input logic [63:0] x);
        return x ^ {33'd0, x[63:33]};
    endfunction

    // keep the lowest n bytes of a word, n from 0 to 8
    function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [3:0] n);
        logic [63:0] r;
        r = w;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= n) begin
                r[8*i +: 8] = 8'd0;
            end
        end
        return r;
    endfunction

    function automatic dp_cmd_t mul_cmd(input dp_op_t op, input mul_const_t csel);
        dp_cmd_t c;
        c.op   = op;
        c.csel = csel;
        return c;
    endfunction

    // microcode: one datapath command per step of the sequence
    function automatic dp_cmd_t mc_step(input logic [STEP_W-1:0] step);
        dp_cmd_t c;
        c = mul_cmd(OP_NONE, MC_A);
        case (step)
            6'd0:  c = mul_cmd(OP_W_K1, MC_A);
            6'd1:  c = mul_cmd(OP_MUL_LL, MC_A);
            6'd2:  c = mul_cmd(OP_MUL_LH, MC_A);
            6'd3:  c = mul_cmd(OP_MUL_HL, MC_A);
            6'd4:  c = mul_cmd(OP_W_ROT31, MC_A);
            6'd5:  c = mul_cmd(OP_MUL_LL, MC_B);
            6'd6:  c = mul_cmd(OP_MUL_LH, MC_B);
            6'd7:  c = mul_cmd(OP_MUL_HL, MC_B);
            6'd8:  c = mul_cmd(OP_K1_ACC, MC_A);
            6'd9:  c = mul_cmd(OP_W_K2, MC_A);
            6'd10: c = mul_cmd(OP_MUL_LL, MC_B);
            6'd11: c = mul_cmd(OP_MUL_LH, MC_B);
            6'd12: c = mul_cmd(OP_MUL_HL, MC_B);
            6'd13: c = mul_cmd(OP_W_ROT33, MC_A);
            6'd14: c = mul_cmd(OP_MUL_LL, MC_A);
            6'd15: c = mul_cmd(OP_MUL_LH, MC_A);
            6'd16: c = mul_cmd(OP_MUL_HL, MC_A);
            6'd17: c = mul_cmd(OP_K2_ACC, MC_A);
            6'd18: c = mul_cmd(OP_MERGE1, MC_A);
            6'd19: c = mul_cmd(OP_MERGE2, MC_A);
            6'd20: c = mul_cmd(OP_FIN_XOR, MC_A);
            6'd21: c = mul_cmd(OP_FIN_ADD1, MC_A);
            6'd22: c = mul_cmd(OP_FIN_ADD2, MC_A);
            6'd23: c = mul_cmd(OP_W_L1_FM, MC_A);
            6'd24: c = mul_cmd(OP_MUL_LL, MC_FA);
            6'd25: c = mul_cmd(OP_MUL_LH, MC_FA);
            6'd26: c = mul_cmd(OP_MUL_HL, MC_FA);
            6'd27: c = mul_cmd(OP_W_ACC_FM, MC_A);
            6'd28: c = mul_cmd(OP_MUL_LL, MC_FB);
            6'd29: c = mul_cmd(OP_MUL_LH, MC_FB);
            6'd30: c = mul_cmd(OP_MUL_HL, MC_FB);
            6'd31: c = mul_cmd(OP_L1_ACC_FM, MC_A);
            6'd32: c = mul_cmd(OP_W_L2_FM, MC_A);
            6'd33: c = mul_cmd(OP_MUL_LL, MC_FA);
            6'd34: c = mul_cmd(OP_MUL_LH, MC_FA);
            6'd35: c = mul_cmd(OP_MUL_HL, MC_FA);
            6'd36: c = mul_cmd(OP_W_ACC_FM, MC_A);
            6'd37: c = mul_cmd(OP_MUL_LL, MC_FB);
            6'd38: c = mul_cmd(OP_MUL_LH, MC_FB);
            6'd39: c = mul_cmd(OP_MUL_HL, MC_FB);
            6'd40: c = mul_cmd(OP_L2_ACC_FM, MC_A);
            6'd41: c = mul_cmd(OP_FIN_ADD1, MC_A);
            6'd42: c = mul_cmd(OP_FIN_ADD2, MC_A);
            6'd43: c = mul_cmd(OP_RESULT, MC_A);
            default: c = mul_cmd(OP_NONE, MC_A);
        endcase
        return c;
    endfunction

endpackage

// ===== design/mm3_datapath.sv =====
// mm3_datapath: hash lanes, byte length, shared 32x32 multiplier and result register
// depends on mm3_pkg; driven by commands from mm3_ctrl

module mm3_datapath
    import mm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic [63:0] s_block_low,
    input  logic [63:0] s_block_high,
    input  logic [4:0]  s_valid_bytes,
    input  logic        s_last_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_low,
    output logic [63:0] m_hash_high
);

    logic [63:0] seed_reg, seed_next;
    logic [63:0] lane1_reg, lane1_next;
    logic [63:0] lane2_reg, lane2_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] k1_reg, k1_next;
    logic [63:0] k2_reg, k2_next;
    logic [63:0] w_reg, w_next;
    logic [63:0] acc_reg, acc_next;
    logic        last_reg, last_next;
    logic        full_reg, full_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_low_reg, out_low_next;
    logic [63:0] out_high_reg, out_high_next;

    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_c;
    logic [63:0] mul_p;
    logic [4:0]  byte_cnt;
    logic [3:0]  n_lo;
    logic [3:0]  n_hi;
    logic [63:0] mix1;
    logic [63:0] mix2;

    always_comb begin
        case (cmd.csel)
            MC_A:    mul_const = MUL_A;
            MC_B:    mul_const = MUL_B;
            MC_FA:   mul_const = FIN_A;
            MC_FB:   mul_const = FIN_B;
            default: mul_const = MUL_A;
        endcase
    end

    // low 64 bits of w * const as three 32x32 partial products
    assign mul_x = (cmd.op == OP_MUL_HL) ? w_reg[63:32] : w_reg[31:0];
    assign mul_c = (cmd.op == OP_MUL_LH) ? mul_const[63:32] : mul_const[31:0];
    assign mul_p = 64'(mul_x) * 64'(mul_c);

    // last word: saturate at a full block; other words always count sixteen
    assign byte_cnt = !s_last_block ? 5'd16 :
                      (s_valid_bytes > 5'd16) ? 5'd16 : s_valid_bytes;
    assign n_lo = (byte_cnt >= 5'd8) ? 4'd8 : byte_cnt[3:0];
    assign n_hi = (byte_cnt > 5'd8) ? 4'(byte_cnt - 5'd8) : 4'd0;

    assign mix1 = rotl27(lane1_reg ^ k1_reg) + lane2_reg;
    assign mix2 = rotl31(lane2_reg ^ k2_reg) + lane1_reg;

    always_comb begin
        seed_next      = seed_reg;
        lane1_next     = lane1_reg;
        lane2_next     = lane2_reg;
        len_next       = len_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;

        case (cmd.op)
            OP_LOAD: begin
                // bytes beyond the count are zeroed before premixing; a short tail only XORs into the lanes
                k1_next   = keep_bytes(s_block_low, n_lo);
                k2_next   = keep_bytes(s_block_high, n_hi);
                last_next = s_last_block;
                full_next = (byte_cnt == 5'd16);
                len_next  = len_reg + 64'(byte_cnt);
            end
            OP_W_K1:     w_next = k1_reg;
            OP_W_K2:     w_next = k2_reg;
            OP_MUL_LL:   acc_next = mul_p;
            OP_MUL_LH,
            OP_MUL_HL:   acc_next = acc_reg + {mul_p[31:0], 32'd0};
            OP_W_ROT31:  w_next = rotl31(acc_reg);
            OP_W_ROT33:  w_next = rotl33(acc_reg);
            OP_K1_ACC:   k1_next = acc_reg;
            OP_K2_ACC:   k2_next = acc_reg;
            OP_MERGE1: begin
                if (full_reg) begin
                    lane1_next = {mix1[61:0], 2'b00} + mix1 + ADD_ONE;
                end else begin
                    lane1_next = lane1_reg ^ k1_reg;
                end
            end
            OP_MERGE2: begin
                if (full_reg) begin
                    lane2_next = {mix2[61:0], 2'b00} + mix2 + ADD_TWO;
                end else begin
                    lane2_next = lane2_reg ^ k2_reg;
                end
            end
            OP_FIN_XOR: begin
                lane1_next = lane1_reg ^ len_reg;
                lane2_next = lane2_reg ^ len_reg;
            end
            OP_FIN_ADD1:  lane1_next = lane1_reg + lane2_reg;
            OP_FIN_ADD2:  lane2_next = lane2_reg + lane1_reg;
            OP_W_L1_FM:   w_next = shr33_xor(lane1_reg);
            OP_W_L2_FM:   w_next = shr33_xor(lane2_reg);
            OP_W_ACC_FM:  w_next = shr33_xor(acc_reg);
            OP_L1_ACC_FM: lane1_next = shr33_xor(acc_reg);
            OP_L2_ACC_FM: lane2_next = shr33_xor(acc_reg);
            OP_RESULT: begin
                out_valid_next = 1'b1;
                out_low_next   = lane1_reg;
                out_high_next  = lane2_reg;
                lane1_next     = seed_reg;
                lane2_next     = seed_reg;
                len_next       = 64'd0;
            end
            default: begin
            end
        endcase

        // new seed restarts any message in progress
        if (cfg_wr_en) begin
            seed_next  = cfg_wr_data;
            lane1_next = cfg_wr_data;
            lane2_next = cfg_wr_data;
            len_next   = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= SEED_RESET;
            lane1_reg     <= SEED_RESET;
            lane2_reg     <= SEED_RESET;
            len_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end else begin
            seed_reg      <= seed_next;
            lane1_reg     <= lane1_next;
            lane2_reg     <= lane2_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k1_reg       <= k1_next;
        k2_reg       <= k2_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        last_reg     <= last_next;
        full_reg     <= full_next;
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_hash_low  = out_low_reg;
    assign m_hash_high = out_high_reg;

endmodule

// ===== design/mm3_ctrl.sv =====
// mm3_ctrl: sequencer that steps the datapath through block mixing and finalisation
// depends on mm3_pkg for the command set and microcode

module mm3_ctrl
    import mm3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = mul_cmd(OP_NONE, MC_A);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd = mul_cmd(OP_LOAD, MC_A);
                end
            end
            S_RUN: begin
                cmd = mc_step(step_reg);
                // hold the hand-over while the previous hash is still unread
                if (step_reg == STEP_RESULT && !status.out_free) begin
                    cmd = mul_cmd(OP_NONE, MC_A);
                end
            end
            default: cmd = mul_cmd(OP_NONE, MC_A);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_RUN;
                        step_reg  <= '0;
                    end
                end
                S_RUN: begin
                    if (step_reg == STEP_BLOCK_END && !status.last) begin
                        state_reg <= S_IDLE;
                    end else if (step_reg == STEP_RESULT) begin
                        if (status.out_free) begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_result_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_RESULT |-> status.out_free)
        else $error("result issued while output register still full");

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while previous word still in progress");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RUN |-> step_reg <= STEP_RESULT)
        else $error("sequencer step beyond end of microcode");

    a_block_end_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && step_reg == STEP_BLOCK_END && !status.last) |=> s_ready)
        else $error("non-final word did not return to idle");

endmodule

// ===== design/murmur3_hash_128.sv =====
// murmur3_hash_128: top level of the streaming MurmurHash3 x64_128 hasher
// depends on mm3_pkg, mm3_ctrl and mm3_datapath
//
//  port group     direction  handshake          contents
//  s_*            in         s_valid/s_ready    16-byte block, valid byte count, last flag
//  m_*            out        m_valid/m_ready    128-bit hash as two 64-bit halves
//  cfg_*          in         cfg_wr_en          seed value, no read-back
//
// a new word is taken only once the previous one is mixed and, if final, its hash finalised,
// a pace set by the single shared 32x32 multiplier (three passes per 64-bit product).
// synchronous active-low reset loads the seed 0xdeadbeefdeadbeef and clears the length.
// the result sits in an output register; a new word is taken while it waits, and only
// the hand-over of the following hash stalls until m_ready frees the register.

module murmur3_hash_128
    import mm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_low,
    input  logic [63:0] s_block_high,
    input  logic [4:0]  s_valid_bytes,
    input  logic        s_last_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_low,
    output logic [63:0] m_hash_high
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mm3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mm3_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_block_low   (s_block_low),
        .s_block_high  (s_block_high),
        .s_valid_bytes (s_valid_bytes),
        .s_last_block  (s_last_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_low    (m_hash_low),
        .m_hash_high   (m_hash_high)
    );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for murmur3_hash_128, the streaming x64_128 hasher
// depends on mm3_pkg and the design sources; hashes are predicted in-bench and checked in order

module tb
    import mm3_pkg::*;
();

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam logic [63:0] ALL_ONES      = {64{1'b1}};

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } hash_word_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [63:0] cfg_wr_data   = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [63:0] s_block_low   = '0;
    logic [63:0] s_block_high  = '0;
    logic [4:0]  s_valid_bytes = '0;
    logic        s_last_block  = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [63:0] m_hash_low;
    logic [63:0] m_hash_high;

    // predicted hasher state
    logic [63:0] seed_q;
    logic [63:0] lane_a;
    logic [63:0] lane_b;
    logic [63:0] byte_count;
    hash_word_t  pending_hashes[$];

    int unsigned error_count    = 0;
    int unsigned words_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    murmur3_hash_128 i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_block_low   (s_block_low),
        .s_block_high  (s_block_high),
        .s_valid_bytes (s_valid_bytes),
        .s_last_block  (s_last_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_low    (m_hash_low),
        .m_hash_high   (m_hash_high)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] scramble_k1(input logic [63:0] k);
        logic [63:0] x;
        x = k * MUL_A;
        x = rol64(x, 31);
        return x * MUL_B;
    endfunction

    function automatic logic [63:0] scramble_k2(input logic [63:0] k);
        logic [63:0] x;
        x = k * MUL_B;
        x = rol64(x, 33);
        return x * MUL_A;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] k);
        logic [63:0] x;
        x = k ^ (k >> 33);
        x = x * FIN_A;
        x = x ^ (x >> 33);
        x = x * FIN_B;
        return x ^ (x >> 33);
    endfunction

    function automatic logic [63:0] byte_mask(input int unsigned n);
        logic [63:0] m;
        if (n >= 8) begin
            m = ALL_ONES;
        end else begin
            m = (64'd1 << (8 * n)) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic [63:0] rand_data();
        logic [63:0] v;
        case ($urandom_range(15))
            0: v = '0;
            1: v = ALL_ONES;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic reload_lanes();
        lane_a     = seed_q;
        lane_b     = seed_q;
        byte_count = '0;
    endtask

    task automatic mix_full(input logic [63:0] lo, input logic [63:0] hi);
        lane_a     = lane_a ^ scramble_k1(lo);
        lane_a     = rol64(lane_a, 27) + lane_b;
        lane_a     = lane_a * 64'd5 + ADD_ONE;
        lane_b     = lane_b ^ scramble_k2(hi);
        lane_b     = rol64(lane_b, 31) + lane_a;
        lane_b     = lane_b * 64'd5 + ADD_TWO;
        byte_count = byte_count + 64'd16;
    endtask

    // fold one accepted word into the lanes; a last word yields one hash
    task automatic absorb_word(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] nv, input logic last);
        int unsigned n;
        logic [63:0] h1;
        logic [63:0] h2;
        hash_word_t  h;
        if (!last) begin
            mix_full(lo, hi);
        end else begin
            n = (nv > 5'd16) ? 16 : int'(nv);
            if (n == 16) begin
                mix_full(lo, hi);
            end else if (n > 0) begin
                if (n > 8) begin
                    lane_b = lane_b ^ scramble_k2(hi & byte_mask(n - 8));
                end
                lane_a     = lane_a ^ scramble_k1(lo & byte_mask(n));
                byte_count = byte_count + 64'(n);
            end
            h1 = lane_a ^ byte_count;
            h2 = lane_b ^ byte_count;
            h1 = h1 + h2;
            h2 = h2 + h1;
            h1 = avalanche(h1);
            h2 = avalanche(h2);
            h1 = h1 + h2;
            h2 = h2 + h1;
            h.lo = h1;
            h.hi = h2;
            pending_hashes.push_back(h);
            reload_lanes();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // called at a rising edge with the block idle
    task automatic write_seed(input logic [63:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        seed_q = value;
        reload_lanes();
        @(posedge aclk);
    endtask

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] nv, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_block_low   <= lo;
        s_block_high  <= hi;
        s_valid_bytes <= nv;
        s_last_block  <= last;
        @(negedge aclk);
        while (!s_ready) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        absorb_word(lo, hi, nv, last);
        words_sent++;
    endtask

    task automatic send_message(input int unsigned blocks, input logic [4:0] tail_bytes);
        for (int i = 0; i < blocks; i++) begin
            send_word(rand_data(), rand_data(), 5'($urandom), 1'b0);
        end
        send_word(rand_data(), rand_data(), tail_bytes, 1'b1);
    endtask

    // wait for every hash, then give any non-final word time to finish
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset_seed_corners();
        logic [4:0] tails[7];
        tails = '{5'd1, 5'd7, 5'd8, 5'd9, 5'd15, 5'd17, 5'd31};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word('0, '0, 5'd0, 1'b1);
        send_word('0, '0, 5'd16, 1'b1);
        send_word(ALL_ONES, ALL_ONES, 5'd16, 1'b1);
        // random bytes beyond the count must be masked off
        foreach (tails[i]) begin
            send_word({$urandom, $urandom}, {$urandom, $urandom}, tails[i], 1'b1);
        end
        // count on a non-final word is ignored
        send_word(rand_data(), rand_data(), 5'd0, 1'b0);
        send_word(rand_data(), rand_data(), 5'd3, 1'b0);
        send_word(rand_data(), rand_data(), 5'd5, 1'b1);
        drain();
    endtask

    task automatic test_seed_restarts_message();
        send_word(rand_data(), rand_data(), 5'd16, 1'b0);
        send_word(rand_data(), rand_data(), 5'd16, 1'b0);
        drain();
        write_seed({$urandom, $urandom});
        send_word(rand_data(), rand_data(), 5'd3, 1'b1);
        drain();
    endtask

    task automatic test_seed_extremes();
        write_seed('0);
        send_message(1, 5'd16);
        send_message(0, 5'd9);
        drain();
        write_seed(ALL_ONES);
        send_message(1, 5'd16);
        send_message(0, 5'd9);
        drain();
        write_seed(SEED_RESET);
    endtask

    task automatic test_random_phase(input int unsigned count, input int unsigned sidle,
                                     input int unsigned rstall);
        int unsigned start;
        int unsigned blocks;
        logic [4:0]  tail;
        case ($urandom_range(3))
            0: write_seed('0);
            1: write_seed(ALL_ONES);
            default: write_seed({$urandom, $urandom});
        endcase
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        start = words_sent;
        while (words_sent - start < count) begin
            blocks = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
            tail   = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                              : 5'($urandom_range(16));
            send_message(blocks, tail);
        end
        drain();
    endtask

    // receiver holds off for a long stretch while single-word messages keep coming
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        repeat (16) send_message(0, 5'($urandom_range(16)));
        drain();
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sampled mid-cycle; the hand-over happens at the next rising edge
    always @(negedge aclk) begin : check_hash
        hash_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch("unexpected hash_low", m_hash_low, '0);
            end else begin
                want = pending_hashes.pop_front();
                if (m_hash_low !== want.lo) begin
                    report_mismatch("hash_low", m_hash_low, want.lo);
                end
                if (m_hash_high !== want.hi) begin
                    report_mismatch("hash_high", m_hash_high, want.hi);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        seed_q = SEED_RESET;
        reload_lanes();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_seed_corners();
        test_seed_restarts_message();
        test_seed_extremes();
        test_random_phase(250, 0, 0);
        test_random_phase(250, 81, 0);
        test_random_phase(250, 0, 81);
        test_random_phase(250, 20, 20);
        test_output_backpressure();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mm3_pkg.sv
design/mm3_datapath.sv
design/mm3_ctrl.sv
design/murmur3_hash_128.sv
tb/tb.sv
